>>> design/tvw_pkg.sv
// ----------------------------------------------------------------------------
// tvw_pkg
// Types and constants shared by the triangle vertex welder.
// ----------------------------------------------------------------------------
package tvw_pkg;

  localparam int TableDepth = 1024;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int CntW       = IdxW + 1;
  localparam int OutIdxW    = 10;

  typedef enum logic [1:0] {
    KIND_POS  = 2'd0,
    KIND_NORM = 2'd1,
    KIND_UV   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_INSERT,
    ST_DECIDE,
    ST_EMIT
  } state_t;

  // request from the controller to the search unit
  typedef struct packed {
    logic        start;
    kind_t       kind;
  } srch_req_t;

  // search unit status
  typedef struct packed {
    logic            done;
    logic            found;
    logic [IdxW-1:0] idx;
  } srch_rsp_t;

  localparam logic [1:0] CORNER_TWO   = 2'd2;
  localparam logic [1:0] CORNER_THREE = 2'd3;

endpackage

>>> design/tvw_tables.sv
// ----------------------------------------------------------------------------
// tvw_tables
// Position, normal and uv tables with registered reads.
// ----------------------------------------------------------------------------
module tvw_tables
  import tvw_pkg::*;
(
  input  logic            clk,
  input  kind_t           rd_kind,
  input  logic [IdxW-1:0] rd_addr,
  output logic [31:0]     rd_a,
  output logic [31:0]     rd_b,
  output logic [31:0]     rd_c,
  input  logic            wr_en,
  input  kind_t           wr_kind,
  input  logic [IdxW-1:0] wr_addr,
  input  logic [31:0]     wr_a,
  input  logic [31:0]     wr_b,
  input  logic [31:0]     wr_c
);

  logic [95:0] pos_mem  [TableDepth];
  logic [95:0] norm_mem [TableDepth];
  logic [63:0] uv_mem   [TableDepth];
  logic [95:0] pos_q_r, norm_q_r;
  logic [63:0] uv_q_r;
  kind_t       kind_r;

  always_ff @(posedge clk) begin
    if (wr_en && wr_kind == KIND_POS) begin
      pos_mem[wr_addr] <= {wr_a, wr_b, wr_c};
    end
    if (wr_en && wr_kind == KIND_NORM) begin
      norm_mem[wr_addr] <= {wr_a, wr_b, wr_c};
    end
    if (wr_en && wr_kind == KIND_UV) begin
      uv_mem[wr_addr] <= {wr_a, wr_b};
    end
    pos_q_r  <= pos_mem[rd_addr];
    norm_q_r <= norm_mem[rd_addr];
    uv_q_r   <= uv_mem[rd_addr];
    kind_r   <= rd_kind;
  end

  always_comb begin
    case (kind_r)
      KIND_POS:  {rd_a, rd_b, rd_c} = pos_q_r;
      KIND_NORM: {rd_a, rd_b, rd_c} = norm_q_r;
      default:   {rd_a, rd_b, rd_c} = {uv_q_r, 32'd0};
    endcase
  end

endmodule

>>> design/tvw_search.sv
// ----------------------------------------------------------------------------
// tvw_search
// Linear scan: one table entry read per cycle, distance test pipelined.
// ----------------------------------------------------------------------------
module tvw_search
  import tvw_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  srch_req_t       req,
  input  logic [CntW-1:0] count,
  input  logic [31:0]     threshold,
  input  logic [31:0]     q_a,
  input  logic [31:0]     q_b,
  input  logic [31:0]     q_c,
  output logic [IdxW-1:0] rd_addr,
  input  logic [31:0]     rd_a,
  input  logic [31:0]     rd_b,
  input  logic [31:0]     rd_c,
  output srch_rsp_t       rsp
);

  logic            busy_r, busy_nxt;
  logic [CntW-1:0] addr_r, addr_nxt;
  logic            v1_r, v2_r, v3_r;
  logic [IdxW-1:0] i1_r, i2_r, i3_r;
  logic [16:0]     da_r, db_r, dc_r;
  logic [31:0]     sa_r, sb_r, sc_r;
  logic            far2_r;
  logic [33:0]     sum;
  logic            hit;
  logic            found_r, found_nxt;
  logic [IdxW-1:0] idx_r, idx_nxt;
  logic            done_r;
  logic            is_uv;

  function automatic logic [16:0] absdiff(input logic [31:0] a, input logic [31:0] b);
    logic signed [32:0] d;
    logic [32:0]        m;
    d = $signed({a[31], a}) - $signed({b[31], b});
    m = d[32] ? 33'(-d) : 33'(d);
    return (m[32:16] != 17'd0) ? 17'h10000 : {1'b0, m[15:0]};
  endfunction

  assign is_uv   = (req.kind == KIND_UV);
  assign rd_addr = addr_r[IdxW-1:0];

  // stage 1: differences, stage 2: squares, stage 3: sum and compare
  always_ff @(posedge clk) begin
    da_r   <= absdiff(rd_a, q_a);
    db_r   <= absdiff(rd_b, q_b);
    dc_r   <= is_uv ? 17'd0 : absdiff(rd_c, q_c);
    sa_r   <= da_r[15:0] * da_r[15:0];
    sb_r   <= db_r[15:0] * db_r[15:0];
    sc_r   <= dc_r[15:0] * dc_r[15:0];
    far2_r <= da_r[16] | db_r[16] | dc_r[16];
    i2_r   <= i1_r;
    i3_r   <= i2_r;
    i1_r   <= addr_r[IdxW-1:0];
  end

  assign sum = 34'(sa_r) + 34'(sb_r) + 34'(sc_r);
  assign hit = v3_r && !far2_r && (sum <= 34'(threshold));

  always_comb begin
    busy_nxt  = busy_r;
    addr_nxt  = addr_r;
    found_nxt = found_r;
    idx_nxt   = idx_r;
    if (req.start) begin
      busy_nxt  = 1'b1;
      addr_nxt  = '0;
      found_nxt = 1'b0;
      idx_nxt   = '0;
    end else if (busy_r) begin
      if (hit && !found_r) begin
        found_nxt = 1'b1;
        idx_nxt   = i3_r;
      end
      if (addr_r < count) begin
        addr_nxt = addr_r + CntW'(1);
      end
      if ((hit || found_r) || (addr_r >= count && !v1_r && !v2_r && !v3_r)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      done_r  <= 1'b0;
      found_r <= 1'b0;
      addr_r  <= '0;
      idx_r   <= '0;
    end else begin
      busy_r  <= busy_nxt;
      addr_r  <= addr_nxt;
      found_r <= found_nxt;
      idx_r   <= idx_nxt;
      v1_r    <= busy_r && !req.start && (addr_r < count) && busy_nxt;
      v2_r    <= v1_r && busy_nxt;
      v3_r    <= v2_r && busy_nxt;
      done_r  <= busy_r && !busy_nxt && !req.start;
    end
  end

  assign rsp.done  = done_r;
  assign rsp.found = found_r;
  assign rsp.idx   = idx_r;

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> !busy_r) else $error("done while busy");
  a_found_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (rsp.done && rsp.found) |-> (CntW'(rsp.idx) < count)) else $error("hit past count");
  a_addr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (addr_r <= count)) else $error("scan past count");

endmodule

>>> design/triangle_vertex_welder.sv
// ----------------------------------------------------------------------------
// triangle_vertex_welder
// Welds triangle corners against position, normal and uv tables.
// ----------------------------------------------------------------------------
// Usage: drive a corner beat on in_* with start high while busy is low.
// Corners 0 and 1 are buffered in registers. Corner 2 welds the
// triangle: each of up to nine searches scans its table one entry a cycle
// through the shared search unit, then per table an insert step for each
// corner and a decide step follow; busy stays high for
// all of it. Results appear on
// out_* with out_valid high for one cycle each: one dropped beat, or three
// corner beats, the last with out_last set. The receiver cannot stall.
// cfg_we writes the match threshold; the user must use it only while busy is low, the block does not enforce this.
// Synchronous reset empties all three tables and clears the threshold;
// table contents are not cleared, fill counts bound every read.
// ----------------------------------------------------------------------------
module triangle_vertex_welder
  import tvw_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_corner,
  input  logic signed [31:0]  in_pos_x,
  input  logic signed [31:0]  in_pos_y,
  input  logic signed [31:0]  in_pos_z,
  input  logic signed [31:0]  in_norm_x,
  input  logic signed [31:0]  in_norm_y,
  input  logic signed [31:0]  in_norm_z,
  input  logic signed [31:0]  in_uv_u,
  input  logic signed [31:0]  in_uv_v,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_wdata,
  output logic                out_valid,
  output logic [OutIdxW-1:0]  out_position_index,
  output logic [OutIdxW-1:0]  out_normal_index,
  output logic [OutIdxW-1:0]  out_uv_index,
  output logic                out_kept,
  output logic                out_overflow,
  output logic                out_last
);

  logic [31:0] thr_r;
  logic [95:0] cpos_r  [3];
  logic [95:0] cnorm_r [3];
  logic [63:0] cuv_r   [3];

  state_t          st_r, st_nxt;
  kind_t           kind_r, kind_nxt;
  logic [1:0]      qs_r, qs_nxt;
  logic [CntW-1:0] pcnt_r, pcnt_nxt, ncnt_r, ncnt_nxt, ucnt_r, ucnt_nxt;
  logic [IdxW-1:0] pidx_r [3];
  logic [IdxW-1:0] nidx_r [3];
  logic [IdxW-1:0] uidx_r [3];
  logic [2:0]      found_r, povf_r, novf_r, uovf_r;
  logic [1:0]      ek_r, ek_nxt;
  logic            drop_r, drop_nxt;

  srch_req_t       req;
  srch_rsp_t       rsp;
  logic [CntW-1:0] cur_cnt;
  logic [31:0]     qa, qb, qc, ra, rb, rc;
  logic [IdxW-1:0] s_addr;
  logic            accept, ins_full, wr_en;

  assign accept = start && !busy;
  assign busy   = (st_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
    if (accept && in_corner != CORNER_THREE) begin
      cpos_r[in_corner]  <= {in_pos_x, in_pos_y, in_pos_z};
      cnorm_r[in_corner] <= {in_norm_x, in_norm_y, in_norm_z};
      cuv_r[in_corner]   <= {in_uv_u, in_uv_v};
    end
  end

  always_comb begin
    case (kind_r)
      KIND_POS:  cur_cnt = pcnt_r;
      KIND_NORM: cur_cnt = ncnt_r;
      default:   cur_cnt = ucnt_r;
    endcase
    case (kind_r)
      KIND_POS:  {qa, qb, qc} = cpos_r[qs_r];
      KIND_NORM: {qa, qb, qc} = cnorm_r[qs_r];
      default:   {qa, qb, qc} = {cuv_r[qs_r], 32'd0};
    endcase
  end

  assign ins_full = (cur_cnt >= CntW'(TableDepth));

  // next state
  always_comb begin
    st_nxt   = st_r;
    kind_nxt = kind_r;
    qs_nxt   = qs_r;
    ek_nxt   = ek_r;
    drop_nxt = drop_r;
    case (st_r)
      ST_IDLE: begin
        if (accept && in_corner == CORNER_TWO) begin
          st_nxt   = ST_SCAN;
          kind_nxt = KIND_POS;
          qs_nxt   = '0;
          drop_nxt = 1'b0;
        end
      end
      ST_SCAN: begin
        st_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (rsp.done) begin
          if (qs_r == 2'd2) begin
            st_nxt = ST_INSERT;
            qs_nxt = '0;
          end else begin
            qs_nxt = qs_r + 2'd1;
            st_nxt = ST_SCAN;
          end
        end
      end
      ST_INSERT: begin
        if (qs_r == 2'd2) begin
          qs_nxt = '0;
          st_nxt = ST_DECIDE;
        end else begin
          qs_nxt = qs_r + 2'd1;
        end
      end
      ST_DECIDE: begin
        case (kind_r)
          KIND_POS: begin
            if (pidx_r[0] == pidx_r[1] || pidx_r[0] == pidx_r[2] ||
                pidx_r[1] == pidx_r[2]) begin
              drop_nxt = 1'b1;
              ek_nxt   = 2'd2;
              st_nxt   = ST_EMIT;
            end else begin
              kind_nxt = KIND_NORM;
              st_nxt   = ST_SCAN;
            end
          end
          KIND_NORM: begin
            kind_nxt = KIND_UV;
            st_nxt   = ST_SCAN;
          end
          default: begin
            ek_nxt = '0;
            st_nxt = ST_EMIT;
          end
        endcase
      end
      ST_EMIT: begin
        if (ek_r == 2'd2) begin
          st_nxt = ST_IDLE;
        end else begin
          ek_nxt = ek_r + 2'd1;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req.start = (st_r == ST_SCAN);
    req.kind  = kind_r;
    wr_en     = (st_r == ST_INSERT) && !found_r[qs_r] && !ins_full;
    pcnt_nxt  = pcnt_r;
    ncnt_nxt  = ncnt_r;
    ucnt_nxt  = ucnt_r;
    if (wr_en) begin
      case (kind_r)
        KIND_POS:  pcnt_nxt = pcnt_r + CntW'(1);
        KIND_NORM: ncnt_nxt = ncnt_r + CntW'(1);
        default:   ucnt_nxt = ucnt_r + CntW'(1);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      kind_r <= KIND_POS;
      qs_r   <= '0;
      ek_r   <= '0;
      drop_r <= 1'b0;
      pcnt_r <= '0;
      ncnt_r <= '0;
      ucnt_r <= '0;
    end else begin
      st_r   <= st_nxt;
      kind_r <= kind_nxt;
      qs_r   <= qs_nxt;
      ek_r   <= ek_nxt;
      drop_r <= drop_nxt;
      pcnt_r <= pcnt_nxt;
      ncnt_r <= ncnt_nxt;
      ucnt_r <= ucnt_nxt;
    end
  end

  // per-corner search and insert results
  always_ff @(posedge clk) begin
    if (st_r == ST_WAIT && rsp.done) begin
      found_r[qs_r] <= rsp.found;
      case (kind_r)
        KIND_POS:  pidx_r[qs_r] <= rsp.idx;
        KIND_NORM: nidx_r[qs_r] <= rsp.idx;
        default:   uidx_r[qs_r] <= rsp.idx;
      endcase
    end
    if (st_r == ST_INSERT) begin
      case (kind_r)
        KIND_POS:  povf_r[qs_r] <= !found_r[qs_r] && ins_full;
        KIND_NORM: novf_r[qs_r] <= !found_r[qs_r] && ins_full;
        default:   uovf_r[qs_r] <= !found_r[qs_r] && ins_full;
      endcase
      if (!found_r[qs_r]) begin
        case (kind_r)
          KIND_POS:  pidx_r[qs_r] <= ins_full ? '0 : cur_cnt[IdxW-1:0];
          KIND_NORM: nidx_r[qs_r] <= ins_full ? '0 : cur_cnt[IdxW-1:0];
          default:   uidx_r[qs_r] <= ins_full ? '0 : cur_cnt[IdxW-1:0];
        endcase
      end
    end
  end

  tvw_search u_search (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .count     (cur_cnt),
    .threshold (thr_r),
    .q_a       (qa),
    .q_b       (qb),
    .q_c       (qc),
    .rd_addr   (s_addr),
    .rd_a      (ra),
    .rd_b      (rb),
    .rd_c      (rc),
    .rsp       (rsp)
  );

  tvw_tables u_tables (
    .clk     (clk),
    .rd_kind (kind_r),
    .rd_addr (s_addr),
    .rd_a    (ra),
    .rd_b    (rb),
    .rd_c    (rc),
    .wr_en   (wr_en),
    .wr_kind (kind_r),
    .wr_addr (cur_cnt[IdxW-1:0]),
    .wr_a    (qa),
    .wr_b    (qb),
    .wr_c    (qc)
  );

  assign out_valid          = (st_r == ST_EMIT);
  assign out_position_index = drop_r ? '0 : OutIdxW'(pidx_r[ek_r]);
  assign out_normal_index   = drop_r ? '0 : OutIdxW'(nidx_r[ek_r]);
  assign out_uv_index       = drop_r ? '0 : OutIdxW'(uidx_r[ek_r]);
  assign out_kept           = !drop_r;
  assign out_overflow       = drop_r ? (|povf_r)
                            : (povf_r[ek_r] | novf_r[ek_r] | uovf_r[ek_r]);
  assign out_last           = (ek_r == 2'd2);

  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("beat while idle");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pcnt_r <= CntW'(TableDepth)) else $error("position count overrun");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid) else $error("beat after last");

endmodule
